### sv/rtcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtcs_pkg;

  localparam logic [31:0] TAG_RIFF         = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE         = 32'h4556_4157;
  localparam logic [31:0] TARGET_TAG_RESET = 32'd1195459159;
  localparam logic [31:0] STOP_TAG_RESET   = 32'd1635017060;

  localparam logic [31:0] RIFF_HEADER_BYTES  = 32'd12;
  localparam logic [32:0] CHUNK_HEADER_BYTES = 33'd8;
  localparam logic [32:0] RIFF_POS_TAG       = 33'd3;
  localparam logic [32:0] RIFF_POS_WAVE      = 33'd11;

  localparam logic [1:0] STATUS_FOUND      = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND  = 2'd2;
  localparam logic [1:0] STATUS_TRUNCATED  = 2'd3;

  localparam int  ADDR_W         = 3;
  localparam logic REG_TARGET_TAG = 1'b0;
  localparam logic REG_STOP_TAG   = 1'b1;

  typedef struct packed {
    logic [31:0] target_tag;
    logic [31:0] stop_tag;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [31:0] data_offset;
    logic [31:0] chunk_length;
  } result_t;

endpackage

`default_nettype wire

### sv/riff_tagged_chunk_scanner.sv
// The byte that decides a verdict passes the input register, and the verdict
// then leaves the result register. Throughput: one byte per cycle while
// no stalled result blocks the input; the scan state updates in a single pass.
// Reset (rst, synchronous): clears scan state and valid flags, and loads the
// target and stop tags with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module riff_tagged_chunk_scanner (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rtcs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic [31:0]                 file_length,
  input  wire logic                        first_byte,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic [1:0]                       status,
  output logic [31:0]                      data_offset,
  output logic [31:0]                      chunk_length
);
  import rtcs_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic        item_q_valid;
  logic [7:0]  item_q_byte;
  logic [31:0] item_q_length;
  logic        item_q_first;
  logic        advance;
  logic        fire;

  assign advance    = !result_valid || !result_stall;
  assign fire       = item_q_valid && advance;
  assign item_stall = item_q_valid && !advance;

  rtcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rtcs_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (item_q_byte),
    .file_length (item_q_length),
    .first_byte  (item_q_first),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q_byte   <= data_byte;
      item_q_length <= file_length;
      item_q_first  <= first_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      status       <= res.status;
      data_offset  <= res.data_offset;
      chunk_length <= res.chunk_length;
    end
  end

endmodule

`default_nettype wire

### sv/rtcs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rtcs_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rtcs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output rtcs_pkg::cfg_t                   cfg
);
  import rtcs_pkg::*;

  logic [31:0] target_tag;
  logic [31:0] stop_tag;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_tag <= TARGET_TAG_RESET;
      stop_tag   <= STOP_TAG_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TARGET_TAG: target_tag <= pwdata;
        REG_STOP_TAG:   stop_tag   <= pwdata;
        default:        target_tag <= target_tag;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TARGET_TAG: prdata = target_tag;
      REG_STOP_TAG:   prdata = stop_tag;
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.target_tag = target_tag;
  assign cfg.stop_tag   = stop_tag;

endmodule

`default_nettype wire

### sv/rtcs_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module rtcs_walker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] file_length,
  input  wire logic        first_byte,
  input  wire rtcs_pkg::cfg_t cfg,
  output rtcs_pkg::result_t res
);
  import rtcs_pkg::*;

  typedef enum logic [1:0] {PH_RIFF, PH_HDR, PH_SKIP} phase_t;

  logic [31:0] byte_position, byte_position_next;
  phase_t      scan_phase, scan_phase_next;
  logic [63:0] header_shift, header_shift_next;
  logic [32:0] skip_remaining, skip_remaining_next;
  logic [31:0] length_latch, length_latch_next;
  logic        verdict_given, verdict_given_next;

  // state as seen after a possible new-file restart
  logic [31:0] e_pos;
  phase_t      e_phase;
  logic [63:0] e_shift;
  logic [32:0] e_skip;
  logic [31:0] e_len;
  logic        e_done;

  logic [63:0] shift_n;
  logic [32:0] hdr_cnt;
  logic [32:0] doff;
  logic [33:0] data_end;
  logic [34:0] next_hdr_end;
  logic [31:0] hdr_tag;
  logic [31:0] hdr_size;

  assign shift_n      = {data_byte, e_shift[63:8]};
  assign hdr_tag      = shift_n[31:0];
  assign hdr_size     = shift_n[63:32];
  assign hdr_cnt      = e_skip + 33'd1;
  assign doff         = {1'b0, e_pos} + 33'd1;
  assign data_end     = {1'b0, doff} + {2'b00, hdr_size};
  assign next_hdr_end = {1'b0, data_end} + {34'd0, hdr_size[0]}
                        + {2'b00, CHUNK_HEADER_BYTES};

  always_comb begin
    if (first_byte) begin
      e_pos   = 32'd0;
      e_phase = PH_RIFF;
      e_shift = 64'd0;
      e_skip  = 33'd0;
      e_len   = file_length;
      e_done  = 1'b0;
    end else begin
      e_pos   = byte_position;
      e_phase = scan_phase;
      e_shift = header_shift;
      e_skip  = skip_remaining;
      e_len   = length_latch;
      e_done  = verdict_given;
    end

    byte_position_next  = e_pos;
    scan_phase_next     = e_phase;
    header_shift_next   = e_shift;
    skip_remaining_next = e_skip;
    length_latch_next   = e_len;
    verdict_given_next  = e_done;

    res.valid        = 1'b0;
    res.status       = STATUS_FOUND;
    res.data_offset  = 32'd0;
    res.chunk_length = 32'd0;

    if (!e_done) begin
      byte_position_next = e_pos + 32'd1;
      header_shift_next  = shift_n;
      case (e_phase)
        PH_RIFF: begin
          if (e_len < RIFF_HEADER_BYTES) begin
            res.valid  = 1'b1;
            res.status = STATUS_BAD_HEADER;
          end else if ({1'b0, e_pos} == RIFF_POS_TAG && shift_n[63:32] != TAG_RIFF) begin
            res.valid  = 1'b1;
            res.status = STATUS_BAD_HEADER;
          end else if ({1'b0, e_pos} == RIFF_POS_WAVE) begin
            if (shift_n[63:32] != TAG_WAVE) begin
              res.valid  = 1'b1;
              res.status = STATUS_BAD_HEADER;
            end else if (e_len < RIFF_HEADER_BYTES + CHUNK_HEADER_BYTES[31:0]) begin
              res.valid  = 1'b1;
              res.status = STATUS_NOT_FOUND;
            end else begin
              scan_phase_next     = PH_HDR;
              skip_remaining_next = 33'd0;
            end
          end
        end
        PH_HDR: begin
          skip_remaining_next = hdr_cnt;
          if (hdr_cnt >= CHUNK_HEADER_BYTES) begin
            if (hdr_tag == cfg.stop_tag) begin
              res.valid  = 1'b1;
              res.status = STATUS_NOT_FOUND;
            end else if (data_end > {2'b00, e_len}) begin
              res.valid  = 1'b1;
              res.status = STATUS_TRUNCATED;
            end else if (hdr_tag == cfg.target_tag) begin
              res.valid        = 1'b1;
              res.status       = STATUS_FOUND;
              res.data_offset  = doff[31:0];
              res.chunk_length = hdr_size;
            end else if (next_hdr_end > {3'b000, e_len}) begin
              res.valid  = 1'b1;
              res.status = STATUS_NOT_FOUND;
            end else begin
              skip_remaining_next = {1'b0, hdr_size} + {32'd0, hdr_size[0]};
              if (hdr_size == 32'd0) begin
                scan_phase_next = PH_HDR;
              end else begin
                scan_phase_next = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (e_skip != 33'd0) begin
            skip_remaining_next = e_skip - 33'd1;
          end
          if (e_skip <= 33'd1) begin
            scan_phase_next = PH_HDR;
          end
        end
        default: begin
          scan_phase_next = e_phase;
        end
      endcase
      if (res.valid) begin
        verdict_given_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= 32'd0;
      scan_phase     <= PH_RIFF;
      header_shift   <= 64'd0;
      skip_remaining <= 33'd0;
      length_latch   <= 32'd0;
      verdict_given  <= 1'b0;
    end else if (fire) begin
      byte_position  <= byte_position_next;
      scan_phase     <= scan_phase_next;
      header_shift   <= header_shift_next;
      skip_remaining <= skip_remaining_next;
      length_latch   <= length_latch_next;
      verdict_given  <= verdict_given_next;
    end
  end

endmodule

`default_nettype wire
